### sv/packed_pixel_glyph_blitter_defines.svh
// assertion macros shared by the blitter rtl
`ifndef PACKED_PIXEL_GLYPH_BLITTER_DEFINES_SVH
`define PACKED_PIXEL_GLYPH_BLITTER_DEFINES_SVH

`ifndef SYNTHESIS

// condition must hold at every edge out of reset
`define PPGB_ASSERT(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("ppgb check failed");

// consequent must hold in the same cycle as the antecedent
`define PPGB_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppgb check failed");

// consequent must hold in the cycle after the antecedent
`define PPGB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ppgb check failed");

`else

`define PPGB_ASSERT(lbl, cond)
`define PPGB_ASSERT_IMP(lbl, ante, cons)
`define PPGB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/ppgb_pkg.sv
// widths, sizes and operation codes of the packed pixel glyph blitter
package ppgb_pkg;

   // store sizes
   localparam int FRAME_BYTES = 6144;
   localparam int GLYPH_COUNT = 128;
   localparam int FRAME_AW    = $clog2(FRAME_BYTES);
   localparam int FONT_DEPTH  = GLYPH_COUNT * 8;
   localparam int FONT_AW     = $clog2(FONT_DEPTH);

   // field widths
   localparam int OP_W     = 3;
   localparam int X_W      = 7;
   localparam int Y_W      = 8;
   localparam int COLOR_W  = 2;
   localparam int GLYPH_W  = 7;
   localparam int FROW_W   = 3;
   localparam int FBITS_W  = 8;
   localparam int RADDR_W  = 13;
   localparam int DATA_W   = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_PLOT  = 3'd0;
   localparam logic [OP_W-1:0] OP_GLYPH = 3'd1;
   localparam logic [OP_W-1:0] OP_DBL   = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
   localparam logic [OP_W-1:0] OP_FONT  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ  = 3'd5;

endpackage

### sv/ppgb_req_if.sv
// request channel: one drawing command per beat
interface ppgb_req_if import ppgb_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [X_W-1:0]       x_pos;
   logic [Y_W-1:0]       y_pos;
   logic [COLOR_W-1:0]   color;
   logic [GLYPH_W-1:0]   glyph_code;
   logic [FROW_W-1:0]    font_row;
   logic [FBITS_W-1:0]   font_bits;
   logic [RADDR_W-1:0]   read_address;

   modport source (
      output valid, operation, x_pos, y_pos, color, glyph_code, font_row, font_bits,
             read_address,
      input  ready
   );

   modport sink (
      input  valid, operation, x_pos, y_pos, color, glyph_code, font_row, font_bits,
             read_address,
      output ready
   );

endinterface

### sv/ppgb_rsp_if.sv
// response channel: one result per beat
interface ppgb_rsp_if import ppgb_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              clipped;

   modport source (
      output valid, read_data, clipped,
      input  ready
   );

   modport sink (
      input  valid, read_data, clipped,
      output ready
   );

endinterface

### sv/packed_pixel_glyph_blitter.sv
// Drawing engine over a 128x192, 2 bit per pixel frame store held in on-chip RAM, plus a
// glyph font RAM. One request beat gives one response beat. The engine works on one
// command at a time; pixels stream through a read-modify-write pipe on the frame RAM at
// one pixel per cycle, with the last write forwarded into the next merge. Plot, glyph and
// double-height glyph pass through the run and drain states, clear writes one byte per
// cycle through the single write port of the frame RAM, and font load and byte read go
// straight to the response. A new request is taken as soon as the engine is idle, even
// while the previous response still waits in its register.
module packed_pixel_glyph_blitter import ppgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ppgb_req_if.sink   req_bus,
   ppgb_rsp_if.source rsp_bus
);

`include "packed_pixel_glyph_blitter_defines.svh"

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_CLEAR = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // font ram index of a glyph row
   function automatic logic [FONT_AW-1:0] font_index(input logic [GLYPH_W-1:0] g,
                                                      input logic [FROW_W-1:0] r);
      logic [15:0] wide;
      wide = 16'({g, 3'b000}) + 16'(r);
      return wide[FONT_AW-1:0];
   endfunction

   // replace one 2 bit pixel inside a byte, leftmost pixel in the top bits
   function automatic logic [7:0] pix_merge(input logic [7:0] b, input logic [1:0] col,
                                            input logic [COLOR_W-1:0] c);
      logic [2:0] sh;
      logic [7:0] mask;
      logic [7:0] val;
      sh   = {~col, 1'b0};
      mask = 8'h03 << sh;
      val  = 8'(c) << sh;
      return (b & ~mask) | val;
   endfunction

   // memories
   logic [7:0]          frame_mem_ff [FRAME_BYTES];
   logic [7:0]          font_mem_ff  [FONT_DEPTH];
   logic [7:0]          frame_q_ff;
   logic [7:0]          font_q_ff;

   // control and payload registers
   logic [2:0]           state_ff, state_in;
   logic [6:0]           pix_cnt_ff, pix_cnt_in;
   logic [FRAME_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [OP_W-1:0]      op_ff;
   logic [X_W-1:0]       x_ff;
   logic [Y_W-1:0]       y_ff;
   logic [COLOR_W-1:0]   color_ff;
   logic [GLYPH_W-1:0]   glyph_ff;
   logic [RADDR_W-1:0]   raddr_ff;
   logic                 clip_ff, clip_in;

   // merge stage registers
   logic                 s1_valid_ff;
   logic [FRAME_AW-1:0]  s1_addr_ff;
   logic                 s1_oob_ff;
   logic [1:0]           s1_col_ff;
   logic [2:0]           s1_bit_ff;

   // forwarding of the previous write
   logic                 fwd_en_ff;
   logic [FRAME_AW-1:0]  fwd_addr_ff;
   logic [7:0]           fwd_data_ff;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_data_ff;
   logic                 rsp_clip_ff;

   logic                 req_accept;
   logic                 rsp_load;
   logic                 glyph_ok;
   logic                 raddr_ok;
   logic [6:0]           pix_last;
   logic [2:0]           pix_j;
   logic [2:0]           pix_r;
   logic [3:0]           row_off;
   logic [7:0]           pix_col;
   logic [8:0]           pix_row;
   logic [13:0]          pix_addr;
   logic                 pix_oob;
   logic                 s1_on;
   logic [7:0]           s1_cur;
   logic                 frame_rd_en;
   logic [FRAME_AW-1:0]  frame_rd_addr;
   logic                 frame_wr_en;
   logic [FRAME_AW-1:0]  frame_wr_addr;
   logic [7:0]           frame_wr_data;
   logic                 font_wr_en;
   logic [FONT_AW-1:0]   font_wr_addr;
   logic [FONT_AW-1:0]   font_rd_addr;

   // handshake
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   assign glyph_ok = (9'(glyph_ff) < 9'(GLYPH_COUNT));
   assign raddr_ok = (17'(raddr_ff) < 17'(FRAME_BYTES));

   // last pixel index of the current command
   always_comb begin
      case (op_ff)
         OP_GLYPH: pix_last = 7'd63;
         OP_DBL:   pix_last = 7'd127;
         default:  pix_last = 7'd0;
      endcase
   end

   // pixel coordinates for the issue stage
   always_comb begin
      pix_j = pix_cnt_ff[2:0];
      case (op_ff)
         OP_GLYPH: begin
            pix_r   = pix_cnt_ff[5:3];
            row_off = {1'b0, pix_cnt_ff[5:3]};
         end
         OP_DBL: begin
            pix_r   = pix_cnt_ff[6:4];
            row_off = {pix_cnt_ff[6:4], pix_cnt_ff[3]};
         end
         default: begin
            pix_r   = 3'd0;
            row_off = 4'd0;
         end
      endcase
      pix_col  = {1'b0, x_ff} + 8'(pix_j);
      pix_row  = {1'b0, y_ff} + 9'(row_off);
      pix_addr = {pix_row, 5'b00000} + 14'(pix_col[7:2]);
      pix_oob  = (17'(pix_addr) >= 17'(FRAME_BYTES));
   end

   // merge stage: pixel enable and forwarded byte
   assign s1_on  = (op_ff == OP_PLOT) || (glyph_ok && font_q_ff[3'd7 - s1_bit_ff]);
   assign s1_cur = (fwd_en_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : frame_q_ff;

   // frame ram ports
   always_comb begin
      frame_rd_en   = 1'b0;
      frame_rd_addr = FRAME_AW'(pix_addr);
      if (state_ff == ST_RUN) begin
         frame_rd_en = !pix_oob;
      end else if (req_accept && (req_bus.operation == OP_READ)) begin
         frame_rd_en   = (17'(req_bus.read_address) < 17'(FRAME_BYTES));
         frame_rd_addr = FRAME_AW'(req_bus.read_address);
      end
      if (state_ff == ST_CLEAR) begin
         frame_wr_en   = 1'b1;
         frame_wr_addr = clr_cnt_ff;
         frame_wr_data = {4{color_ff}};
      end else begin
         frame_wr_en   = s1_valid_ff && s1_on && !s1_oob_ff;
         frame_wr_addr = s1_addr_ff;
         frame_wr_data = pix_merge(s1_cur, s1_col_ff, color_ff);
      end
   end

   // font ram ports
   assign font_wr_en   = req_accept && (req_bus.operation == OP_FONT) &&
                         (9'(req_bus.glyph_code) < 9'(GLYPH_COUNT));
   assign font_wr_addr = font_index(req_bus.glyph_code, req_bus.font_row);
   assign font_rd_addr = font_index(glyph_ff, pix_r);

   // frame ram
   always_ff @(posedge clock) begin
      if (frame_wr_en) begin
         frame_mem_ff[frame_wr_addr] <= frame_wr_data;
      end
      if (frame_rd_en) begin
         frame_q_ff <= frame_mem_ff[frame_rd_addr];
      end
   end

   // font ram
   always_ff @(posedge clock) begin
      if (font_wr_en) begin
         font_mem_ff[font_wr_addr] <= req_bus.font_bits;
      end
      if (state_ff == ST_RUN) begin
         font_q_ff <= font_mem_ff[font_rd_addr];
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      pix_cnt_in   = pix_cnt_ff;
      clr_cnt_in   = clr_cnt_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && s1_on && s1_oob_ff) begin
         clip_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pix_cnt_in = 7'd0;
               clr_cnt_in = '0;
               clip_in    = 1'b0;
               case (req_bus.operation)
                  OP_PLOT, OP_GLYPH, OP_DBL: state_in = ST_RUN;
                  OP_CLEAR:                 state_in = ST_CLEAR;
                  default:                  state_in = ST_DONE;
               endcase
            end
         end
         ST_RUN: begin
            if (pix_cnt_ff == pix_last) begin
               state_in = ST_DRAIN;
            end else begin
               pix_cnt_in = pix_cnt_ff + 7'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (17'(clr_cnt_ff) == 17'(FRAME_BYTES - 1)) begin
               state_in = ST_DONE;
            end else begin
               clr_cnt_in = clr_cnt_ff + FRAME_AW'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pix_cnt_ff   <= 7'd0;
         clr_cnt_ff   <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         fwd_en_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pix_cnt_ff   <= pix_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= (state_ff == ST_RUN);
         fwd_en_ff    <= frame_wr_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_bus.operation;
         x_ff     <= req_bus.x_pos;
         y_ff     <= req_bus.y_pos;
         color_ff <= req_bus.color;
         glyph_ff <= req_bus.glyph_code;
         raddr_ff <= req_bus.read_address;
      end
      s1_addr_ff  <= FRAME_AW'(pix_addr);
      s1_oob_ff   <= pix_oob;
      s1_col_ff   <= pix_col[1:0];
      s1_bit_ff   <= pix_j;
      fwd_addr_ff <= frame_wr_addr;
      fwd_data_ff <= frame_wr_data;
      if (rsp_load) begin
         rsp_data_ff <= ((op_ff == OP_READ) && raddr_ok) ? frame_q_ff : '0;
         rsp_clip_ff <= clip_ff;
      end
   end

   // response beat
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;
   assign rsp_bus.clipped   = rsp_clip_ff;

   // checks
   `PPGB_ASSERT_IMP(a_no_write_idle, state_ff == ST_IDLE, !frame_wr_en)
   `PPGB_ASSERT_IMP(a_merge_in_run, s1_valid_ff, (state_ff == ST_RUN) || (state_ff == ST_DRAIN))
   `PPGB_ASSERT_IMP(a_write_in_range, frame_wr_en, 17'(frame_wr_addr) < 17'(FRAME_BYTES))
   `PPGB_ASSERT_IMP(a_clip_draw_only, clip_ff, (op_ff == OP_PLOT) || (op_ff == OP_GLYPH) || (op_ff == OP_DBL))
   `PPGB_ASSERT_NEXT(a_done_to_idle, rsp_load, (state_ff == ST_IDLE) && rsp_valid_ff)

endmodule
